FILE: hw/rtl/uic_pkg.sv
package uic_pkg;

  // Largest Ethernet frame the block will build, in bytes
  localparam int FRAME_BYTES = 4096;

  // Ethernet + IPv4 + UDP header bytes in front of the payload
  localparam int HDR_BYTES   = 42;
  // IPv4 + UDP header bytes counted in the IPv4 total length
  localparam int IP_UDP_HDR  = 28;
  // UDP header bytes counted in the UDP length
  localparam int UDP_HDR     = 8;

  // Payload byte counter
  localparam int COUNT_W     = 13;
  localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
  // First count at which a further byte no longer fits in the frame
  localparam int COUNT_LIMIT = (FRAME_BYTES - HDR_BYTES < COUNT_MAX) ?
                               (FRAME_BYTES - HDR_BYTES) : COUNT_MAX;

  // Payload sum: at most COUNT_MAX bytes, half of them shifted by 8
  localparam int SUM_W       = 29;
  // Raw checksum accumulation before folding
  localparam int ACC_W       = 30;

  // Fixed header words
  localparam logic [15:0] IP_VER_IHL   = 16'h4500;
  localparam logic [15:0] IP_TTL_PROTO = 16'h4011;
  localparam logic [15:0] UDP_PROTO    = 16'h0011;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_IP   = 1'b0,
    CFG_SRC_PORT = 1'b1
  } cfg_idx_e;

  // One input item
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic        last_byte;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [15:0] ip_checksum;
    logic [15:0] udp_checksum;
    logic [11:0] ip_total_length;
    logic [11:0] udp_length;
    logic [12:0] frame_length;
    logic [15:0] src_port_used;
    logic        too_long;
  } result_t;

  // Finished packet handed from the accumulator to the header stage
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    logic               overflow;
    logic [31:0]        dst_ip;
    logic [15:0]        dst_port;
  } pkt_t;

  // Ones-complement fold of a raw sum down to 16 bits
  function automatic logic [15:0] fold16(input logic [ACC_W-1:0] s);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = 17'(s[15:0]) + 17'(s[ACC_W-1:16]);
    s2 = 17'(s1[15:0]) + 17'(s1[16]);
    return s2[15:0];
  endfunction

endpackage

FILE: hw/rtl/uic_in_if.sv
interface uic_in_if;
  import uic_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/uic_out_if.sv
interface uic_out_if;
  import uic_pkg::*;

  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/uic_hdr_calc.sv
module uic_hdr_calc (
  input  uic_pkg::pkt_t    pkt_i,
  input  logic [31:0]      src_ip_i,
  input  logic [15:0]      src_port_i,
  output uic_pkg::result_t res_o
);
  import uic_pkg::*;

  logic [ACC_W-1:0] tlen;
  logic [ACC_W-1:0] ulen;
  logic [ACC_W-1:0] flen;
  logic [15:0]      sport;
  logic [ACC_W-1:0] addr_sum;
  logic [ACC_W-1:0] ip_sum;
  logic [ACC_W-1:0] udp_sum;

  // Lengths from the payload count
  assign tlen = ACC_W'(pkt_i.count) + ACC_W'(IP_UDP_HDR);
  assign ulen = ACC_W'(pkt_i.count) + ACC_W'(UDP_HDR);
  assign flen = ACC_W'(pkt_i.count) + ACC_W'(HDR_BYTES);

  // Unbound source port falls back to the destination port
  assign sport = (src_port_i != 16'd0) ? src_port_i : pkt_i.dst_port;

  // Address words shared by both checksums
  assign addr_sum = ACC_W'(src_ip_i[31:16]) + ACC_W'(src_ip_i[15:0])
                  + ACC_W'(pkt_i.dst_ip[31:16]) + ACC_W'(pkt_i.dst_ip[15:0]);

  // IPv4 header: fixed words, total length and addresses
  assign ip_sum = ACC_W'(IP_VER_IHL) + ACC_W'(IP_TTL_PROTO) + tlen + addr_sum;

  // UDP: pseudo-header, UDP header (length twice) and payload
  assign udp_sum = addr_sum + ACC_W'(UDP_PROTO) + ulen + ulen
                 + ACC_W'(sport) + ACC_W'(pkt_i.dst_port) + ACC_W'(pkt_i.sum);

  // Oversized packet reports only the flag
  always_comb begin
    res_o = '0;
    if (pkt_i.overflow) begin
      res_o.too_long = 1'b1;
    end else begin
      res_o.ip_checksum     = ~fold16(ip_sum);
      res_o.udp_checksum    = ~fold16(udp_sum);
      res_o.ip_total_length = tlen[11:0];
      res_o.udp_length      = ulen[11:0];
      res_o.frame_length    = flen[12:0];
      res_o.src_port_used   = sport;
    end
  end

endmodule

FILE: hw/rtl/udp_ipv4_checksum_builder.sv
// UDP/IPv4 checksum builder. Payload bytes stream in on in_i at one transfer
// per clock while in_i.ready is high; each byte is added to a ones-complement
// running sum (even offsets as the high byte of a big-endian word) and counted.
// The last_byte transfer (with or without a byte) closes the packet into pkt_q,
// then out_o registers its header values: IPv4 header checksum, UDP checksum
// with pseudo-header, IPv4/UDP/frame lengths and the UDP source port used. The
// accumulator add sets the rate, one byte per cycle unless out_o stalls; the
// header stage is pipelined so a new packet can start right after the last one
// ends. Bytes that would push the frame past the maximum size are dropped; that
// packet's result carries only too_long. The user must write src_ip and
// src_port through the cfg port while the block is idle; this is not enforced.
module udp_ipv4_checksum_builder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uic_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [uic_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  uic_in_if.sink                         in_i,
  uic_out_if.source                      out_o
);
  import uic_pkg::*;

  localparam logic [COUNT_W-1:0] CountLimit = COUNT_W'(COUNT_LIMIT);

  // Configuration
  logic [31:0] src_ip_q;
  logic [15:0] src_port_q;

  // Running packet state
  logic [SUM_W-1:0]   sum_q, sum_d, sum_n;
  logic [COUNT_W-1:0] cnt_q, cnt_d, cnt_n;
  logic               ovf_q, ovf_d, ovf_n;
  logic [SUM_W-1:0]   byte_add;
  logic               refuse;

  // Pipeline
  logic     pkt_vld_q, pkt_vld_d;
  pkt_t     pkt_q, pkt_d;
  logic     out_vld_q, out_vld_d;
  result_t  res_q, res_d;
  in_item_t item;
  logic     in_xfer;
  logic     out_adv;
  logic     pkt_move;

  assign item     = in_i.payload;
  assign out_adv  = !out_vld_q || out_o.ready;
  assign pkt_move = pkt_vld_q && out_adv;
  assign in_i.ready = rst_ni && (!pkt_vld_q || out_adv);
  assign in_xfer  = in_i.valid && in_i.ready;

  // Byte placement in the 16-bit word and the frame size check
  assign byte_add = cnt_q[0] ? SUM_W'(item.payload_byte)
                             : SUM_W'({item.payload_byte, 8'h00});
  assign refuse   = ovf_q || (cnt_q >= CountLimit);

  // Accumulator update for the incoming transfer
  always_comb begin
    sum_n = sum_q;
    cnt_n = cnt_q;
    ovf_n = ovf_q;
    if (item.has_byte) begin
      if (refuse) begin
        ovf_n = 1'b1;
      end else begin
        sum_n = sum_q + byte_add;
        cnt_n = cnt_q + COUNT_W'(1);
      end
    end
  end

  // Next accumulator and packet stage
  always_comb begin
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    pkt_vld_d = pkt_move ? 1'b0 : pkt_vld_q;
    pkt_d     = pkt_q;
    if (in_xfer) begin
      if (item.last_byte) begin
        sum_d          = '0;
        cnt_d          = '0;
        ovf_d          = 1'b0;
        pkt_vld_d      = 1'b1;
        pkt_d.sum      = sum_n;
        pkt_d.count    = cnt_n;
        pkt_d.overflow = ovf_n;
        pkt_d.dst_ip   = item.dst_ip;
        pkt_d.dst_port = item.dst_port;
      end else begin
        sum_d = sum_n;
        cnt_d = cnt_n;
        ovf_d = ovf_n;
      end
    end
  end

  assign out_vld_d = out_adv ? pkt_vld_q : out_vld_q;

  // Header fields from the finished packet
  uic_hdr_calc u_hdr_calc (
    .pkt_i      (pkt_q),
    .src_ip_i   (src_ip_q),
    .src_port_i (src_port_q),
    .res_o      (res_d)
  );

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_ip_q   <= '0;
      src_port_q <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      pkt_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SRC_IP:   src_ip_q   <= cfg_wdata_i[31:0];
          CFG_SRC_PORT: src_port_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      pkt_vld_q <= pkt_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pkt_q <= pkt_d;
    if (pkt_move) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = res_q;

endmodule

FILE: hw/rtl/uic_checker.sv
module uic_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input uic_pkg::in_item_t in_payload,
  input logic             out_valid,
  input logic             out_ready,
  input uic_pkg::result_t out_payload
);
  import uic_pkg::*;

  logic in_last_xfer;
  assign in_last_xfer = in_valid && in_ready && in_payload.last_byte;

  // Oversized packet: only the flag is set
  a_too_long_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_payload.too_long |->
      out_payload.ip_checksum == 16'd0 && out_payload.udp_checksum == 16'd0 &&
      out_payload.ip_total_length == 12'd0 && out_payload.udp_length == 12'd0 &&
      out_payload.frame_length == 13'd0 && out_payload.src_port_used == 16'd0)
    else $error("too_long result carries nonzero fields");

  // Lengths agree with each other
  a_len_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_payload.too_long |->
      out_payload.ip_total_length == out_payload.udp_length + 12'd20 &&
      out_payload.frame_length[11:0] == out_payload.udp_length + 12'd34)
    else $error("length fields inconsistent");

  // A fresh result follows an end-of-packet transfer
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_last_xfer, 2))
    else $error("result without end of packet");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");

endmodule

bind udp_ipv4_checksum_builder uic_checker u_uic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .in_payload  (in_i.payload),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_payload (out_o.payload)
);
